### src/sbmq_pkg.sv
`default_nettype none

package sbmq_pkg;

  // default sizing of the shared store
  localparam int unsigned ENTRIES_DEF = 16;
  localparam int unsigned QUEUES_DEF  = 4;

  // fixed field widths
  localparam int unsigned DATA_W = 32;
  localparam int unsigned QID_W  = 2;

  // operation codes
  localparam logic OP_ENQ = 1'b0;
  localparam logic OP_DEQ = 1'b1;

  // result status codes
  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_OVERFLOW  = 2'd1,
    ST_UNDERFLOW = 2'd2
  } status_e;

endpackage

`default_nettype wire

### src/sbmq_entry_store.sv
`default_nettype none

module sbmq_entry_store #(
  parameter int unsigned ENTRIES = sbmq_pkg::ENTRIES_DEF
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  // link port
  input  wire logic                             link_rd_en_i,
  input  wire logic [$clog2(ENTRIES+1)-1:0]     link_rd_addr_i,
  output logic      [$clog2(ENTRIES+1)-1:0]     link_rd_data_o,
  input  wire logic                             link_we_i,
  input  wire logic [$clog2(ENTRIES+1)-1:0]     link_wr_addr_i,
  input  wire logic [$clog2(ENTRIES+1)-1:0]     link_wr_data_i,
  // data port
  input  wire logic                             data_rd_en_i,
  input  wire logic [$clog2(ENTRIES+1)-1:0]     data_rd_addr_i,
  output logic      [sbmq_pkg::DATA_W-1:0]      data_rd_data_o,
  input  wire logic                             data_we_i,
  input  wire logic [$clog2(ENTRIES+1)-1:0]     data_wr_addr_i,
  input  wire logic [sbmq_pkg::DATA_W-1:0]      data_wr_data_i
);

  import sbmq_pkg::*;

  localparam int unsigned AW = $clog2(ENTRIES);
  localparam int unsigned PW = $clog2(ENTRIES + 1);

  logic [DATA_W-1:0] data_mem [ENTRIES];
  logic [PW-1:0]     link_mem [ENTRIES];

  logic [DATA_W-1:0] data_rd_q;
  logic [PW-1:0]     link_rd_q;
  logic [PW-1:0]     link_addr_q;
  logic              link_fresh_q;
  logic [PW-1:0]     fill_q;

  // word memory
  always_ff @(posedge clk_i) begin
    if (data_we_i) begin
      data_mem[data_wr_addr_i[AW-1:0]] <= data_wr_data_i;
    end
    if (data_rd_en_i) begin
      data_rd_q <= data_mem[data_rd_addr_i[AW-1:0]];
    end
  end

  // link memory, read side remembers whether the entry is still untouched
  always_ff @(posedge clk_i) begin
    if (link_we_i) begin
      link_mem[link_wr_addr_i[AW-1:0]] <= link_wr_data_i;
    end
    if (link_rd_en_i) begin
      link_rd_q    <= link_mem[link_rd_addr_i[AW-1:0]];
      link_addr_q  <= link_rd_addr_i;
      link_fresh_q <= (link_rd_addr_i >= fill_q);
    end
  end

  // entries at or above the fill mark were never allocated since reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q <= '0;
    end else if (data_we_i && (data_wr_addr_i >= fill_q)) begin
      fill_q <= PW'(data_wr_addr_i + 1'b1);
    end
  end

  // untouched entries still link to their successor, the last one to null
  assign link_rd_data_o = link_fresh_q ? PW'(link_addr_q + 1'b1) : link_rd_q;
  assign data_rd_data_o = data_rd_q;

endmodule

`default_nettype wire

### src/sbmq_queue_table.sv
`default_nettype none

module sbmq_queue_table #(
  parameter int unsigned ENTRIES = sbmq_pkg::ENTRIES_DEF,
  parameter int unsigned QUEUES  = sbmq_pkg::QUEUES_DEF
) (
  input  wire logic                                          clk_i,
  input  wire logic                                          rst_ni,
  input  wire logic                                          rd_en_i,
  input  wire logic [((QUEUES > 1) ? $clog2(QUEUES) : 1)-1:0] rd_addr_i,
  output logic      [$clog2(ENTRIES+1)-1:0]                  rd_head_o,
  output logic      [$clog2(ENTRIES+1)-1:0]                  rd_tail_o,
  input  wire logic                                          we_i,
  input  wire logic [((QUEUES > 1) ? $clog2(QUEUES) : 1)-1:0] wr_addr_i,
  input  wire logic [$clog2(ENTRIES+1)-1:0]                  wr_head_i,
  input  wire logic [$clog2(ENTRIES+1)-1:0]                  wr_tail_i
);

  import sbmq_pkg::*;

  localparam int unsigned PW  = $clog2(ENTRIES + 1);
  localparam logic [PW-1:0] NIL = PW'(ENTRIES);

  logic [2*PW-1:0] ptr_mem [QUEUES];
  logic [2*PW-1:0] ptr_rd_q;
  logic            vld_rd_q;
  logic [QUEUES-1:0] valid_q;

  // head and tail pointers per queue
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      ptr_mem[wr_addr_i] <= {wr_head_i, wr_tail_i};
    end
    if (rd_en_i) begin
      ptr_rd_q <= ptr_mem[rd_addr_i];
      vld_rd_q <= valid_q[rd_addr_i];
    end
  end

  // a queue that was never written since reset reads as empty
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (we_i) begin
      valid_q[wr_addr_i] <= 1'b1;
    end
  end

  assign rd_head_o = vld_rd_q ? ptr_rd_q[2*PW-1:PW] : NIL;
  assign rd_tail_o = vld_rd_q ? ptr_rd_q[PW-1:0]    : NIL;

endmodule

`default_nettype wire

### src/shared_buffer_multi_queue_unit.sv
// Several FIFO queues share one store of ENTRIES words, each queue a linked list with head
// and tail pointers and the unused entries on a linked free list. Pulse start_i while busy_o
// is low to issue one enqueue or dequeue; exactly one result beat follows on done_o, held for
// one cycle, and it must be taken then. busy_o stays high until the write-back is done, since
// the queue pointer table and the link and word memories each have a registered read, and a
// dequeue reads the table first and then the entry at its head before it writes back.
// Overflow, underflow and an out-of-range queue_id_i change nothing.
// No clearing pass follows reset; the block accepts work as soon as reset is released.
`default_nettype none

module shared_buffer_multi_queue_unit #(
  parameter int unsigned ENTRIES = sbmq_pkg::ENTRIES_DEF,
  parameter int unsigned QUEUES  = sbmq_pkg::QUEUES_DEF
) (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                start_i,
  output logic                                     busy_o,
  input  wire logic                                operation_i,
  input  wire logic [sbmq_pkg::QID_W-1:0]          queue_id_i,
  input  wire logic signed [sbmq_pkg::DATA_W-1:0]  data_in_i,
  output logic                                     done_o,
  output logic      [1:0]                          status_o,
  output logic signed [sbmq_pkg::DATA_W-1:0]       data_out_o
);

  import sbmq_pkg::*;

  localparam int unsigned PW  = $clog2(ENTRIES + 1);
  localparam int unsigned QIW = (QUEUES > 1) ? $clog2(QUEUES) : 1;
  localparam int unsigned QCW = ($clog2(QUEUES + 1) > QID_W) ? $clog2(QUEUES + 1) : QID_W;
  localparam logic [PW-1:0] NIL = PW'(ENTRIES);

  typedef enum logic [1:0] {
    S_IDLE,
    S_ENQ,
    S_DEQ_RD,
    S_DEQ_WR
  } state_e;

  state_e            state_q, state_d;
  logic [PW-1:0]     free_head_q, free_head_d;
  logic [QIW-1:0]    qidx_q;
  logic              in_range_q;
  logic [DATA_W-1:0] word_q;
  logic              done_q, done_d;
  status_e           status_q, status_d;
  logic [DATA_W-1:0] dout_q, dout_d;

  logic              accept;
  logic [QCW-1:0]    qid_ext;
  logic              qid_in_range;
  logic [QIW-1:0]    qidx_in;

  // memory controls
  logic              qt_rd_en, qt_we;
  logic [PW-1:0]     qt_head, qt_tail, qt_wr_head, qt_wr_tail;
  logic              link_rd_en, link_we;
  logic [PW-1:0]     link_rd_addr, link_rd_data, link_wr_addr, link_wr_data;
  logic              data_rd_en, data_we;
  logic [DATA_W-1:0] data_rd_data;

  assign accept       = start_i && (state_q == S_IDLE);
  assign qid_ext      = QCW'(queue_id_i);
  assign qid_in_range = (qid_ext < QCW'(QUEUES));
  assign qidx_in      = qid_ext[QIW-1:0];

  sbmq_queue_table #(
    .ENTRIES (ENTRIES),
    .QUEUES  (QUEUES)
  ) u_queue_table (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_en_i   (qt_rd_en),
    .rd_addr_i (qidx_in),
    .rd_head_o (qt_head),
    .rd_tail_o (qt_tail),
    .we_i      (qt_we),
    .wr_addr_i (qidx_q),
    .wr_head_i (qt_wr_head),
    .wr_tail_i (qt_wr_tail)
  );

  sbmq_entry_store #(
    .ENTRIES (ENTRIES)
  ) u_entry_store (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .link_rd_en_i   (link_rd_en),
    .link_rd_addr_i (link_rd_addr),
    .link_rd_data_o (link_rd_data),
    .link_we_i      (link_we),
    .link_wr_addr_i (link_wr_addr),
    .link_wr_data_i (link_wr_data),
    .data_rd_en_i   (data_rd_en),
    .data_rd_addr_i (qt_head),
    .data_rd_data_o (data_rd_data),
    .data_we_i      (data_we),
    .data_wr_addr_i (free_head_q),
    .data_wr_data_i (word_q)
  );

  // sequencer: reads, then the write-back of pointers and links
  always_comb begin
    state_d      = state_q;
    free_head_d  = free_head_q;
    done_d       = 1'b0;
    status_d     = ST_OK;
    dout_d       = '0;
    qt_rd_en     = 1'b0;
    qt_we        = 1'b0;
    qt_wr_head   = qt_head;
    qt_wr_tail   = qt_tail;
    link_rd_en   = 1'b0;
    link_rd_addr = free_head_q;
    link_we      = 1'b0;
    link_wr_addr = qt_tail;
    link_wr_data = free_head_q;
    data_rd_en   = 1'b0;
    data_we      = 1'b0;

    unique case (state_q)
      S_IDLE: begin
        if (start_i) begin
          // fetch the queue pointers and the free head's successor
          qt_rd_en   = 1'b1;
          link_rd_en = 1'b1;
          state_d    = (operation_i == OP_DEQ) ? S_DEQ_RD : S_ENQ;
        end
      end
      S_ENQ: begin
        state_d = S_IDLE;
        done_d  = 1'b1;
        if (in_range_q) begin
          if (free_head_q == NIL) begin
            status_d = ST_OVERFLOW;
          end else begin
            // take the free head and append it behind the tail
            free_head_d = link_rd_data;
            data_we     = 1'b1;
            qt_we       = 1'b1;
            qt_wr_tail  = free_head_q;
            if (qt_head == NIL) begin
              qt_wr_head = free_head_q;
            end else begin
              link_we      = 1'b1;
              link_wr_addr = qt_tail;
              link_wr_data = free_head_q;
            end
          end
        end
      end
      S_DEQ_RD: begin
        if (!in_range_q) begin
          state_d = S_IDLE;
          done_d  = 1'b1;
        end else if (qt_head == NIL) begin
          state_d  = S_IDLE;
          done_d   = 1'b1;
          status_d = ST_UNDERFLOW;
        end else begin
          // fetch word and successor of the head entry
          link_rd_en   = 1'b1;
          link_rd_addr = qt_head;
          data_rd_en   = 1'b1;
          state_d      = S_DEQ_WR;
        end
      end
      S_DEQ_WR: begin
        state_d = S_IDLE;
        done_d  = 1'b1;
        dout_d  = data_rd_data;
        // unlink the head, a single entry leaves the queue empty
        qt_we = 1'b1;
        if (qt_head == qt_tail) begin
          qt_wr_head = NIL;
          qt_wr_tail = NIL;
        end else begin
          qt_wr_head = link_rd_data;
          qt_wr_tail = qt_tail;
        end
        // push the entry back onto the free list
        link_we      = 1'b1;
        link_wr_addr = qt_head;
        link_wr_data = free_head_q;
        free_head_d  = qt_head;
      end
    endcase
  end

  // state, captured command and result beat
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      free_head_q <= '0;
      qidx_q      <= '0;
      in_range_q  <= 1'b0;
      word_q      <= '0;
      done_q      <= 1'b0;
      status_q    <= ST_OK;
      dout_q      <= '0;
    end else begin
      state_q     <= state_d;
      free_head_q <= free_head_d;
      done_q      <= done_d;
      status_q    <= status_d;
      dout_q      <= dout_d;
      if (accept) begin
        qidx_q     <= qidx_in;
        in_range_q <= qid_in_range;
        word_q     <= data_in_i;
      end
    end
  end

  assign busy_o     = (state_q != S_IDLE);
  assign done_o     = done_q;
  assign status_o   = status_q;
  assign data_out_o = dout_q;

endmodule

`default_nettype wire
